@@ src/smag_pkg.sv @@
// smag_pkg: shared types for sorted_max_adjacent_gap.
// No dependencies.
package smag_pkg;
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_BUILD,
    ST_EXTRACT,
    ST_EX_RD,
    ST_EX_SWAP,
    ST_SIFT_START,
    ST_SIFT_ROOTV,
    ST_SIFT_CHK,
    ST_SIFT_L,
    ST_SIFT_R,
    ST_SCAN_RD,
    ST_SCAN,
    ST_DONE
  } smag_state_t;
endpackage

@@ src/sorted_max_adjacent_gap.sv @@
// sorted_max_adjacent_gap: largest gap between neighbors of a sorted set.
// Depends on smag_pkg.
// Loading: after a non-last point busy stays low, so points can load back to
// back. On the last point the block heap-sorts the store in place (one memory
// read per cycle) and then scans n entries at one per cycle. The result
// strobes for one cycle; the receiver cannot stall.
// Reset (rst_n low, synchronous) clears count, drop flag and sequencer; the
// coordinate memory is not cleared, only entries below the count are read.
module sorted_max_adjacent_gap import smag_pkg::*; #(
  parameter int MAX_POINTS  = 1024,
  parameter int COORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_x_coord,
  input  logic        in_last_point,
  output logic        out_valid,
  output logic [31:0] out_max_gap,
  output logic        out_overflow
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = AW + 1;

  // Single-port-read, single-port-write store with a registered read.
  logic [COORD_WIDTH-1:0] mem [MAX_POINTS];
  logic [COORD_WIDTH-1:0] rd_q;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic                   wr_en;
  logic [COORD_WIDTH-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  smag_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;       // stored points
  logic          drop_r, drop_nxt;
  logic [CW-1:0] heap_n_r, heap_n_nxt; // current heap size
  logic [CW-1:0] build_r, build_nxt;   // next build root (+1)
  logic [CW-1:0] root_r, root_nxt;     // hole position of the running sift
  logic [COORD_WIDTH-1:0] va_r, va_nxt, vr_r, vr_nxt;
  logic [COORD_WIDTH-1:0] gap_r, gap_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          ph_r, ph_nxt;         // 1 while building the heap

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
    end
    heap_n_r <= heap_n_nxt; build_r <= build_nxt; root_r <= root_nxt;
    va_r <= va_nxt; vr_r <= vr_nxt;
    gap_r <= gap_nxt; idx_r <= idx_nxt; ph_r <= ph_nxt;
  end

  // Children of the hole: left at 2*root+1, right at 2*root+2.
  logic [CW:0]            c1, c2;
  logic [CW-1:0]          last_idx, idx_inc;
  logic                   right_wins;
  logic [COORD_WIDTH-1:0] big_v, diff;
  logic [CW-1:0]          big_i;
  smag_state_t            sift_ret;

  assign c1         = {root_r, 1'b1};
  assign c2         = c1 + (CW+1)'(1);
  assign last_idx   = heap_n_r - CW'(1);
  assign idx_inc    = idx_r + CW'(1);
  assign right_wins = rd_q > va_r;
  assign big_v      = right_wins ? rd_q : va_r;
  assign big_i      = right_wins ? c2[CW-1:0] : c1[CW-1:0];
  assign diff       = rd_q - va_r;     // sorted, never negative
  assign sift_ret   = ph_r ? ST_BUILD : ST_EXTRACT;

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; drop_nxt = drop_r;
    heap_n_nxt = heap_n_r; build_nxt = build_r; root_nxt = root_r;
    va_nxt = va_r; vr_nxt = vr_r;
    gap_nxt = gap_r; idx_nxt = idx_r; ph_nxt = ph_r;
    rd_addr = '0; wr_addr = '0; wr_en = 1'b0; wr_data = '0;
    busy = (state_r != ST_LOAD);
    out_valid = 1'b0;
    out_max_gap = 32'(gap_r);
    out_overflow = drop_r;
    unique case (state_r)
      ST_LOAD: begin
        if (start) begin
          if (cnt_r < CW'(MAX_POINTS)) begin
            wr_en = 1'b1; wr_addr = cnt_r[AW-1:0];
            wr_data = COORD_WIDTH'(in_x_coord);
            cnt_nxt = cnt_r + CW'(1);
          end else drop_nxt = 1'b1;   // store full: point dropped, last or not
          if (in_last_point) state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        heap_n_nxt = cnt_r; build_nxt = cnt_r >> 1; ph_nxt = 1'b1;
        state_nxt = ST_BUILD;
      end
      // Build phase: sift each internal node, last one first.
      ST_BUILD: begin
        if (build_r != '0) begin
          root_nxt = build_r - CW'(1); build_nxt = build_r - CW'(1);
          state_nxt = ST_SIFT_START;
        end else begin
          ph_nxt = 1'b0; state_nxt = ST_EXTRACT;
        end
      end
      // Extraction: move the max to the end, then sift the old last value from 0.
      ST_EXTRACT: begin
        if (heap_n_r < CW'(2)) begin
          gap_nxt = '0; idx_nxt = CW'(1); rd_addr = '0;
          state_nxt = ST_SCAN_RD;
        end else begin
          rd_addr = '0; state_nxt = ST_EX_RD;
        end
      end
      ST_EX_RD: begin
        va_nxt = rd_q; rd_addr = last_idx[AW-1:0];
        state_nxt = ST_EX_SWAP;
      end
      ST_EX_SWAP: begin
        vr_nxt = rd_q;
        wr_en = 1'b1; wr_addr = last_idx[AW-1:0]; wr_data = va_r;
        heap_n_nxt = last_idx; root_nxt = '0;
        state_nxt = ST_SIFT_CHK;
      end
      ST_SIFT_START: begin
        rd_addr = root_r[AW-1:0]; state_nxt = ST_SIFT_ROOTV;
      end
      ST_SIFT_ROOTV: begin
        vr_nxt = rd_q; state_nxt = ST_SIFT_CHK;
      end
      // The sifted value rides in vr_r; larger children move up into the hole,
      // and vr_r lands where the descent stops. Reads are always below the
      // last write, so no forwarding is needed.
      ST_SIFT_CHK: begin
        if (c1 >= {1'b0, heap_n_r}) begin
          wr_en = 1'b1; wr_addr = root_r[AW-1:0]; wr_data = vr_r;
          state_nxt = sift_ret;
        end else begin
          rd_addr = c1[AW-1:0]; state_nxt = ST_SIFT_L;
        end
      end
      ST_SIFT_L: begin
        if (c2 < {1'b0, heap_n_r}) begin
          va_nxt = rd_q; rd_addr = c2[AW-1:0]; state_nxt = ST_SIFT_R;
        end else if (vr_r >= rd_q) begin
          wr_en = 1'b1; wr_addr = root_r[AW-1:0]; wr_data = vr_r;
          state_nxt = sift_ret;
        end else begin
          wr_en = 1'b1; wr_addr = root_r[AW-1:0]; wr_data = rd_q;
          root_nxt = c1[CW-1:0]; state_nxt = ST_SIFT_CHK;
        end
      end
      ST_SIFT_R: begin
        if (vr_r >= big_v) begin
          wr_en = 1'b1; wr_addr = root_r[AW-1:0]; wr_data = vr_r;
          state_nxt = sift_ret;
        end else begin
          wr_en = 1'b1; wr_addr = root_r[AW-1:0]; wr_data = big_v;
          root_nxt = big_i; state_nxt = ST_SIFT_CHK;
        end
      end
      ST_SCAN_RD: begin
        // rd_q holds a[0]
        va_nxt = rd_q;
        if (idx_r >= cnt_r) state_nxt = ST_DONE;
        else begin
          rd_addr = idx_r[AW-1:0]; state_nxt = ST_SCAN;
        end
      end
      // One entry per cycle: rd_q is a[idx], va_r is a[idx-1].
      ST_SCAN: begin
        if (diff > gap_r) gap_nxt = diff;
        va_nxt = rd_q; idx_nxt = idx_inc;
        if (idx_inc >= cnt_r) state_nxt = ST_DONE;
        else rd_addr = idx_inc[AW-1:0];
      end
      ST_DONE: begin
        out_valid = 1'b1;
        cnt_nxt = '0; drop_nxt = 1'b0; state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end
endmodule
